/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

/* src/owm_pkg.sv */
package owm_pkg;

   localparam int REG_COUNT = 8;
   localparam int REG_WIDTH = 10;
   localparam int REG_IDX_WIDTH = 3;

   typedef logic [REG_IDX_WIDTH-1:0] reg_idx_type;
   typedef logic [REG_COUNT-1:0][REG_WIDTH-1:0] cfg_regs_type;

   localparam reg_idx_type REG_RESET_LOW     = 3'd0;
   localparam reg_idx_type REG_RESET_RELEASE = 3'd1;
   localparam reg_idx_type REG_RESET_RECOVER = 3'd2;
   localparam reg_idx_type REG_SHORT_LOW     = 3'd3;
   localparam reg_idx_type REG_ONE_TAIL      = 3'd4;
   localparam reg_idx_type REG_ZERO_LOW      = 3'd5;
   localparam reg_idx_type REG_ZERO_RECOVER  = 3'd6;
   localparam reg_idx_type REG_READ_TAIL     = 3'd7;

   // power-on slot timings, register 0 in the low slice
   localparam cfg_regs_type CFG_DEFAULTS = {
      10'd13, 10'd6, 10'd10, 10'd13, 10'd1, 10'd100, 10'd10, 10'd50
   };

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RESET = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_HIGH = 4'd2,
      PH_RST_REC  = 4'd3,
      PH_W1_LOW   = 4'd4,
      PH_W1_TAIL  = 4'd5,
      PH_W0_LOW   = 4'd6,
      PH_W0_REC   = 4'd7,
      PH_RD_LOW   = 4'd8,
      PH_RD_TAIL  = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      DRV_INPUT = 2'd0,
      DRV_LOW   = 2'd1,
      DRV_HIGH  = 2'd2
   } drive_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       line;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic       drive_enable;
      logic       drive_value;
      logic       busy;
      logic       done;
      logic [7:0] read_data;
      logic       presence;
      logic       rejected;
   } result_type;

endpackage

/* src/owm_front.sv */
module owm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [7:0]            req_write_data,
   input  logic                  req_line_in,
   output logic                  entry_valid,
   output owm_pkg::entry_type    entry,
   input  logic                  entry_pop,
   output owm_pkg::q_status_type q_status
);

   owm_pkg::entry_type entries_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   owm_pkg::cmd_type   cmd;
   logic               push;
   logic               pop;

   // decode the item kind
   always_comb begin
      case (req_kind)
         owm_pkg::CMD_RESET: cmd = owm_pkg::CMD_RESET;
         owm_pkg::CMD_WRITE: cmd = owm_pkg::CMD_WRITE;
         owm_pkg::CMD_READ:  cmd = owm_pkg::CMD_READ;
         default:            cmd = owm_pkg::CMD_TICK;
      endcase
   end

   assign req_ready   = (count_ff != 2'd2);
   assign push        = req_valid && req_ready;
   assign entry_valid = (count_ff != 2'd0);
   assign pop         = entry_pop && entry_valid;
   assign entry       = entries_ff[rd_ptr_ff];

   assign q_status.empty = (count_ff == 2'd0);
   assign q_status.full  = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= '{cmd: cmd, data: req_write_data, line: req_line_in};
      end
   end

endmodule

/* src/owm_csr.sv */
module owm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [owm_pkg::REG_IDX_WIDTH-1:0]    csr_index,
   input  logic [owm_pkg::REG_WIDTH-1:0]        csr_wdata,
   output owm_pkg::cfg_regs_type                cfg_regs
);

   owm_pkg::cfg_regs_type regs_ff, regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         regs_in[csr_index] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= owm_pkg::CFG_DEFAULTS;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign cfg_regs = regs_ff;

endmodule

/* src/owm_back.sv */
module owm_back #(
   parameter int BITS_PER_BYTE = 8,
   parameter int COUNT_WIDTH   = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  entry_valid,
   input  owm_pkg::entry_type    entry,
   output logic                  entry_pop,
   input  owm_pkg::cfg_regs_type cfg_regs,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output owm_pkg::result_type   result
);

   localparam int SHW  = (BITS_PER_BYTE > 8) ? BITS_PER_BYTE : 8;
   localparam int IDXW = (BITS_PER_BYTE > 1) ? $clog2(BITS_PER_BYTE) : 1;
   localparam int DW   = (COUNT_WIDTH > owm_pkg::REG_WIDTH) ? COUNT_WIDTH : owm_pkg::REG_WIDTH;
   localparam logic [DW-1:0]   COUNT_MAX = DW'({COUNT_WIDTH{1'b1}});
   localparam logic [IDXW-1:0] LAST_BIT  = IDXW'(BITS_PER_BYTE - 1);

   owm_pkg::phase_type       phase_ff, phase_in;
   owm_pkg::cmd_type         op_ff, op_in;
   owm_pkg::drive_type       drive_ff, drive_in;
   logic [COUNT_WIDTH-1:0]   tick_ff, tick_in;
   logic [IDXW-1:0]          bit_ff, bit_in;
   logic [SHW-1:0]           shift_ff, shift_in;
   logic                     pres_ff, pres_in;
   logic [7:0]               hold_ff, hold_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   owm_pkg::result_type      result_ff, result_in;

   owm_pkg::phase_type       next_ph;
   owm_pkg::reg_idx_type     sel;
   logic                     last;
   logic                     rejected;
   logic                     done;
   logic [COUNT_WIDTH-1:0]   tick_inc;
   logic [DW-1:0]            raw;
   logic [DW-1:0]            dur;
   logic                     fire;

   assign fire      = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign entry_pop = fire;

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      drive_in = drive_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      hold_in  = hold_ff;
      rejected = 1'b0;
      done     = 1'b0;
      next_ph  = owm_pkg::PH_IDLE;
      sel      = owm_pkg::REG_RESET_LOW;
      last     = 1'b0;
      tick_inc = '0;
      raw      = '0;
      dur      = '0;

      // front of the tick: start a command or flag a late one
      if (phase_ff == owm_pkg::PH_IDLE) begin
         if (entry.cmd != owm_pkg::CMD_TICK) begin
            op_in   = entry.cmd;
            bit_in  = '0;
            tick_in = '0;
            case (entry.cmd)
               owm_pkg::CMD_RESET: phase_in = owm_pkg::PH_RST_LOW;
               owm_pkg::CMD_WRITE: begin
                  shift_in = SHW'(entry.data);
                  phase_in = shift_in[0] ? owm_pkg::PH_W1_LOW : owm_pkg::PH_W0_LOW;
               end
               default: begin
                  shift_in = '0;
                  phase_in = owm_pkg::PH_RD_LOW;
               end
            endcase
         end
      end else if (entry.cmd != owm_pkg::CMD_TICK) begin
         rejected = 1'b1;
      end

      // one tick of the running phase
      if (phase_in != owm_pkg::PH_IDLE) begin
         case (phase_in)
            owm_pkg::PH_RST_LOW: begin
               drive_in = owm_pkg::DRV_LOW;
               sel      = owm_pkg::REG_RESET_LOW;
               next_ph  = owm_pkg::PH_RST_HIGH;
            end
            owm_pkg::PH_RST_HIGH: begin
               drive_in = owm_pkg::DRV_HIGH;
               sel      = owm_pkg::REG_RESET_RELEASE;
               next_ph  = owm_pkg::PH_RST_REC;
            end
            owm_pkg::PH_RST_REC: begin
               drive_in = owm_pkg::DRV_INPUT;
               sel      = owm_pkg::REG_RESET_RECOVER;
               last     = 1'b1;
               if (tick_in == '0) begin
                  pres_in = entry.line;
               end
            end
            owm_pkg::PH_W1_LOW: begin
               drive_in = owm_pkg::DRV_LOW;
               sel      = owm_pkg::REG_SHORT_LOW;
               next_ph  = owm_pkg::PH_W1_TAIL;
            end
            owm_pkg::PH_W1_TAIL: begin
               drive_in = owm_pkg::DRV_HIGH;
               sel      = owm_pkg::REG_ONE_TAIL;
               last     = 1'b1;
            end
            owm_pkg::PH_W0_LOW: begin
               drive_in = owm_pkg::DRV_LOW;
               sel      = owm_pkg::REG_ZERO_LOW;
               next_ph  = owm_pkg::PH_W0_REC;
            end
            owm_pkg::PH_W0_REC: begin
               drive_in = owm_pkg::DRV_HIGH;
               sel      = owm_pkg::REG_ZERO_RECOVER;
               last     = 1'b1;
            end
            owm_pkg::PH_RD_LOW: begin
               drive_in = owm_pkg::DRV_LOW;
               sel      = owm_pkg::REG_SHORT_LOW;
               next_ph  = owm_pkg::PH_RD_TAIL;
            end
            owm_pkg::PH_RD_TAIL: begin
               drive_in = owm_pkg::DRV_INPUT;
               sel      = owm_pkg::REG_READ_TAIL;
               last     = 1'b1;
               if (tick_in == '0) begin
                  shift_in[bit_in] = shift_in[bit_in] | entry.line;
               end
            end
            default: begin
               sel = owm_pkg::REG_RESET_LOW;
            end
         endcase

         // zero counts as one tick, long counts clip to the counter range
         tick_inc = tick_in + 1'b1;
         raw      = DW'(cfg_regs[sel]);
         if (raw == '0) begin
            dur = DW'(1);
         end else if (raw > COUNT_MAX) begin
            dur = COUNT_MAX;
         end else begin
            dur = raw;
         end

         if (DW'(tick_inc) < dur) begin
            tick_in = tick_inc;
         end else begin
            tick_in = '0;
            if (!last) begin
               phase_in = next_ph;
            end else if (phase_in != owm_pkg::PH_RST_REC && bit_in != LAST_BIT) begin
               bit_in = bit_in + 1'b1;
               if (op_in == owm_pkg::CMD_WRITE) begin
                  phase_in = shift_in[bit_in] ? owm_pkg::PH_W1_LOW : owm_pkg::PH_W0_LOW;
               end else begin
                  phase_in = owm_pkg::PH_RD_LOW;
               end
            end else begin
               if (op_in == owm_pkg::CMD_READ) begin
                  hold_in = shift_in[7:0];
               end
               phase_in = owm_pkg::PH_IDLE;
               op_in    = owm_pkg::CMD_TICK;
               done     = 1'b1;
            end
         end
      end

      result_in.drive_enable = (drive_in != owm_pkg::DRV_INPUT);
      result_in.drive_value  = (drive_in == owm_pkg::DRV_HIGH);
      result_in.busy         = (phase_in != owm_pkg::PH_IDLE);
      result_in.done         = done;
      result_in.read_data    = hold_in;
      result_in.presence     = pres_in;
      result_in.rejected     = rejected;

      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owm_pkg::PH_IDLE;
         op_ff        <= owm_pkg::CMD_TICK;
         drive_ff     <= owm_pkg::DRV_INPUT;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         pres_ff      <= 1'b1;
         hold_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= phase_in;
            op_ff    <= op_in;
            drive_ff <= drive_in;
            tick_ff  <= tick_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            pres_ff  <= pres_in;
            hold_ff  <= hold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

/* src/onewire_master_slot_timer_top.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | kind, write_data, line_in
// rsp     | out       | rsp_valid/rsp_ready  | drive pins, busy, done, read data,
//         |           |                      | presence, rejected
// csr     | in        | csr_write_enable     | csr_index, csr_wdata (no wait)
//
// one tick item per clock while rsp_ready allows; each item turns into exactly
// one beat; a request beat is registered in the two-entry input queue and its
// result beat in the output register
// synchronous active-high reset; no clearing pass, slot timings return to
// their power-on values
// either side may stall alone: the queue absorbs rsp back-pressure and
// req_ready drops only when both queue entries hold beats
`include "assert_macros.svh"

module onewire_master_slot_timer_top #(
   parameter int BITS_PER_BYTE = 8,
   parameter int COUNT_WIDTH   = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic [7:0]                        req_write_data,
   input  logic                              req_line_in,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pin_drive_enable,
   output logic                              rsp_pin_drive_value,
   output logic                              rsp_busy_res,
   output logic                              rsp_done_res,
   output logic [7:0]                        rsp_read_data,
   output logic                              rsp_presence_level,
   output logic                              rsp_rejected,
   // slot timing registers
   input  logic                              csr_write_enable,
   input  logic [owm_pkg::REG_IDX_WIDTH-1:0] csr_index,
   input  logic [owm_pkg::REG_WIDTH-1:0]     csr_wdata
);

   // queue between the decoder and the slot engine
   logic                  entry_valid;
   logic                  entry_pop;
   owm_pkg::entry_type    entry;
   owm_pkg::q_status_type q_status;
   owm_pkg::cfg_regs_type cfg_regs;
   owm_pkg::result_type   result;

   // front: decode kind and buffer beats
   owm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_write_data (req_write_data),
      .req_line_in    (req_line_in),
      .entry_valid    (entry_valid),
      .entry          (entry),
      .entry_pop      (entry_pop),
      .q_status       (q_status)
   );

   // slot timing registers
   owm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg_regs         (cfg_regs)
   );

   // back: phase sequencer, tick counter, bit shifter, output register
   owm_back #(
      .BITS_PER_BYTE (BITS_PER_BYTE),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (entry_valid),
      .entry       (entry),
      .entry_pop   (entry_pop),
      .cfg_regs    (cfg_regs),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .result      (result)
   );

   // split the result beat onto its ports
   assign rsp_pin_drive_enable = result.drive_enable;
   assign rsp_pin_drive_value  = result.drive_value;
   assign rsp_busy_res         = result.busy;
   assign rsp_done_res         = result.done;
   assign rsp_read_data        = result.read_data;
   assign rsp_presence_level   = result.presence;
   assign rsp_rejected         = result.rejected;

   // a finishing tick never reports busy
   `ASSERT_IMPLIES(a_done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   // driving high implies the pin is an output
   `ASSERT_IMPLIES(a_high_is_driven, clock, reset, rsp_valid && rsp_pin_drive_value,
      rsp_pin_drive_enable)
   // a rejected command only happens inside a running command
   `ASSERT_IMPLIES(a_reject_in_cmd, clock, reset, rsp_valid && rsp_rejected,
      rsp_busy_res || rsp_done_res)
   // a full queue holds beats and blocks the request side
   `ASSERT_IMPLIES(a_full_blocks, clock, reset, q_status.full, !q_status.empty && !req_ready)

endmodule
